/* rtl/mpeg2_program_stream_demux_macros.svh */
// Assertion macros shared by the demux modules.
`ifndef MPEG2_PROGRAM_STREAM_DEMUX_MACROS_SVH
`define MPEG2_PROGRAM_STREAM_DEMUX_MACROS_SVH
// Assert that an antecedent implies a consequent on the same edge.
`define PSD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Assert that an antecedent implies a consequent on the next edge.
`define PSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* rtl/psd_pkg.sv */
// Shared types and constants of the program stream demux.
package psd_pkg;
	typedef enum logic [3:0] {
		PH_BEGIN, PH_SCAN, PH_PACK, PH_STUFF, PH_PACK_CODE, PH_SYS, PH_SKIP, PH_CODE,
		PH_PAD_LEN, PH_PES_HDR, PH_PES_PTS, PH_PES_SKIP, PH_PAYLOAD, PH_STOPPED
	} phase_t;

	typedef enum logic [2:0] {
		K_PAYLOAD = 3'd0, K_SCR = 3'd1, K_PTS = 3'd2, K_ERROR = 3'd3, K_END = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		E_START = 3'd0, E_MPEG1 = 3'd1, E_MARKER = 3'd2, E_SCRAMBLED = 3'd3, E_LENGTH = 3'd4
	} err_t;

	typedef enum logic [1:0] {
		REG_STRICT = 2'd0, REG_FEN = 2'd1, REG_FID = 2'd2, REG_FMASK = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  stream_id;
		logic [7:0]  data_byte;
		logic [32:0] ts_base;
		logic [8:0]  ts_ext;
		logic [2:0]  error_code;
		logic        last_of_packet;
	} result_t;

	typedef struct packed {
		logic strict_mode;
		logic filter_enable;
		logic [7:0] filter_id;
		logic [7:0] filter_mask;
	} cfg_t;

	localparam int QueueDepth = 4;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 8;
	localparam logic [31:0] PackCode = 32'h0000_01BA;
	localparam logic [31:0] SystemCode = 32'h0000_01BB;
endpackage

/* rtl/psd_if.sv */
// Valid/ready channel interfaces for bytes and results.
interface psd_byte_if;
	logic valid;
	logic ready;
	logic [7:0] in_byte;
	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface psd_result_if;
	logic valid;
	logic ready;
	logic [2:0]  kind;
	logic [7:0]  stream_id;
	logic [7:0]  data_byte;
	logic [32:0] ts_base;
	logic [8:0]  ts_ext;
	logic [2:0]  error_code;
	logic        last_of_packet;
	modport source (output valid, output kind, output stream_id, output data_byte,
		output ts_base, output ts_ext, output error_code, output last_of_packet,
		input ready);
	modport sink (input valid, input kind, input stream_id, input data_byte,
		input ts_base, input ts_ext, input error_code, input last_of_packet,
		output ready);
endinterface

/* rtl/psd_parser.sv */
// Front end: byte parser that classifies stream bytes into results.
`include "mpeg2_program_stream_demux_macros.svh"
module psd_parser (
	input  logic            clk,
	input  logic            arst_n,
	input  psd_pkg::cfg_t   cfg,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      in_byte,
	input  logic            q_full,
	output logic            res_valid,
	output psd_pkg::result_t res
);
	psd_pkg::phase_t phase_q, phase_d;
	logic [31:0] shift_q, shift_d;
	logic [15:0] count_q, count_d;
	logic [15:0] rem_q, rem_d;
	logic [7:0]  hlen_q, hlen_d;
	logic [15:0] flags_q, flags_d;
	logic [7:0]  cur_id_q, cur_id_d;
	logic [41:0] stamp_q, stamp_d;
	logic        fire;
	logic [31:0] sh_in;
	logic [7:0]  b;
	logic [15:0] rem_dec;
	logic [7:0]  hlen_dec;
	logic [32:0] scr_base, pts_val;
	logic [8:0]  scr_ext;
	logic [2:0]  pack_err;
	logic [7:0]  id;
	logic        match, pts_flag;
	logic [16:0] need_len;
	logic [7:0]  need;
	logic [4:0]  c;

	assign in_ready = !q_full;
	assign fire = in_valid && in_ready;
	assign b = in_byte;
	assign sh_in = {shift_q[23:0], b};
	assign rem_dec = (rem_q != 16'd0) ? rem_q - 16'd1 : 16'd0;
	assign hlen_dec = (hlen_q != 8'd0) ? hlen_q - 8'd1 : 8'd0;

	// pack header fields: bytes 0..3 in shift, byte 4 in flags low, byte 5 is b
	always_comb begin
		scr_base = {shift_q[29:27], shift_q[25:16], shift_q[15:11], shift_q[9:8],
			shift_q[7:0], flags_q[7:3]};
		scr_ext = {flags_q[1:0], b[7:1]};
		if (!shift_q[26])
			pack_err = 3'd2;
		else if (shift_q[31:30] != 2'b01 || !shift_q[10] || !flags_q[2] || !b[0])
			pack_err = 3'd3;
		else
			pack_err = 3'd0;
		pts_val = {shift_q[27:25], shift_q[23:16], shift_q[15:9], shift_q[7:0], b[7:1]};
		c = {shift_q[29:28], shift_q[24], 2'b00};
		id = sh_in[7:0];
		match = cfg.filter_enable && (((id ^ cfg.filter_id) & cfg.filter_mask) == 8'd0);
		pts_flag = flags_q[7];
		need = pts_flag ? 8'd5 : 8'd0;
		need_len = 17'd3 + {9'd0, b};
	end

	always_comb begin
		phase_d = phase_q;
		shift_d = shift_q;
		count_d = count_q;
		rem_d = rem_q;
		hlen_d = hlen_q;
		flags_d = flags_q;
		cur_id_d = cur_id_q;
		stamp_d = stamp_q;
		res_valid = 1'b0;
		res = '0;
		if (fire) begin
			count_d = count_q + 16'd1;
			case (phase_q)
				psd_pkg::PH_BEGIN: begin
					shift_d = sh_in;
					if (count_q == 16'd3) begin
						if (sh_in == psd_pkg::PackCode) begin
							phase_d = psd_pkg::PH_PACK;
							count_d = '0;
						end else begin
							res_valid = 1'b1;
							res.kind = psd_pkg::K_ERROR;
							res.error_code = psd_pkg::E_START;
							phase_d = cfg.strict_mode ? psd_pkg::PH_STOPPED : psd_pkg::PH_SCAN;
							count_d = '0;
							if (!cfg.strict_mode) shift_d = '1;
						end
					end
				end
				psd_pkg::PH_SCAN: begin
					shift_d = sh_in;
					count_d = count_q;
					if (sh_in == psd_pkg::PackCode) begin
						phase_d = psd_pkg::PH_PACK;
						count_d = '0;
					end
				end
				psd_pkg::PH_PACK: begin
					if (count_q < 16'd4) shift_d = sh_in;
					else if (count_q == 16'd4) flags_d = {8'd0, b};
					else if (count_q == 16'd5) begin
						// latch the clock reference before the flags hold the verdict
						flags_d = {13'd0, pack_err};
						stamp_d = {scr_base, scr_ext};
					end else if (count_q >= 16'd9) begin
						count_d = '0;
						if (flags_q != 16'd0) begin
							res_valid = 1'b1;
							res.kind = psd_pkg::K_ERROR;
							res.error_code = 3'(flags_q - 16'd1);
							phase_d = cfg.strict_mode ? psd_pkg::PH_STOPPED : psd_pkg::PH_SCAN;
							if (!cfg.strict_mode) shift_d = '1;
						end else begin
							rem_d = {13'd0, b[2:0]};
							phase_d = (b[2:0] != 3'd0) ? psd_pkg::PH_STUFF
								: psd_pkg::PH_PACK_CODE;
							res_valid = 1'b1;
							res.kind = psd_pkg::K_SCR;
							res.ts_base = stamp_q[41:9];
							res.ts_ext = stamp_q[8:0];
						end
					end
				end
				psd_pkg::PH_STUFF, psd_pkg::PH_SKIP: begin
					count_d = count_q;
					rem_d = rem_dec;
					if (rem_dec == 16'd0) begin
						count_d = '0;
						phase_d = (phase_q == psd_pkg::PH_STUFF) ? psd_pkg::PH_PACK_CODE
							: psd_pkg::PH_CODE;
					end
				end
				psd_pkg::PH_PACK_CODE, psd_pkg::PH_CODE: begin
					shift_d = sh_in;
					if (count_q == 16'd3) begin
						count_d = '0;
						if (phase_q == psd_pkg::PH_PACK_CODE && sh_in == psd_pkg::SystemCode)
							phase_d = psd_pkg::PH_SYS;
						else if (sh_in[31:8] != 24'h000001 || !((id >= 8'hC0 && id <= 8'hEF)
							|| id == 8'hBD || id == 8'hB9 || id == 8'hBA || id == 8'hBC
							|| id == 8'hBE || id == 8'hBF || id == 8'hF0 || id == 8'hF1
							|| id == 8'hF2 || id == 8'hF8 || id == 8'hFF)) begin
							res_valid = 1'b1;
							res.kind = psd_pkg::K_ERROR;
							res.error_code = psd_pkg::E_START;
							phase_d = cfg.strict_mode ? psd_pkg::PH_STOPPED : psd_pkg::PH_SCAN;
							if (!cfg.strict_mode) shift_d = '1;
						end else if ((id >= 8'hC0 && id <= 8'hEF) || id == 8'hBD) begin
							cur_id_d = id;
							phase_d = match ? psd_pkg::PH_PES_HDR : psd_pkg::PH_PAD_LEN;
						end else if (id == 8'hB9) begin
							if (cfg.strict_mode) begin
								phase_d = psd_pkg::PH_STOPPED;
								res_valid = 1'b1;
								res.kind = psd_pkg::K_END;
							end else begin
								phase_d = psd_pkg::PH_SCAN;
								shift_d = '1;
							end
						end else if (id == 8'hBA)
							phase_d = psd_pkg::PH_PACK;
						else
							phase_d = psd_pkg::PH_PAD_LEN;
					end
				end
				psd_pkg::PH_SYS: begin
					if (count_q == 16'd0) rem_d = {8'd0, b};
					else if (count_q == 16'd1) rem_d = {rem_q[7:0], b};
					else if (count_q == 16'd2) flags_d = {b, 8'd0};
					else if (count_q == 16'd4) flags_d = {flags_q[15:8], b};
					else if (count_q >= 16'd7) begin
						count_d = '0;
						if (!flags_q[15] || !flags_q[0] || rem_q < 16'd6) begin
							res_valid = 1'b1;
							res.kind = psd_pkg::K_ERROR;
							res.error_code = (!flags_q[15] || !flags_q[0]) ? psd_pkg::E_MARKER
								: psd_pkg::E_LENGTH;
							phase_d = cfg.strict_mode ? psd_pkg::PH_STOPPED : psd_pkg::PH_SCAN;
							if (!cfg.strict_mode) shift_d = '1;
						end else begin
							rem_d = rem_q - 16'd6;
							phase_d = (rem_q != 16'd6) ? psd_pkg::PH_SKIP : psd_pkg::PH_CODE;
						end
					end
				end
				psd_pkg::PH_PAD_LEN: begin
					if (count_q == 16'd0) rem_d = {8'd0, b};
					else begin
						rem_d = {rem_q[7:0], b};
						count_d = '0;
						phase_d = ({rem_q[7:0], b} != 16'd0) ? psd_pkg::PH_SKIP
							: psd_pkg::PH_CODE;
					end
				end
				psd_pkg::PH_PES_HDR: begin
					if (count_q == 16'd0) rem_d = {8'd0, b};
					else if (count_q == 16'd1) rem_d = {rem_q[7:0], b};
					else if (count_q == 16'd2) flags_d = {b, 8'd0};
					else if (count_q == 16'd3) flags_d = {flags_q[15:8], b};
					else begin
						count_d = '0;
						hlen_d = b;
						if (flags_q[15:14] != 2'b10 || flags_q[13:12] != 2'b00
							|| b < need || {1'b0, rem_q} < need_len) begin
							res_valid = 1'b1;
							res.kind = psd_pkg::K_ERROR;
							res.error_code = (flags_q[15:14] != 2'b10) ? psd_pkg::E_MARKER
								: (flags_q[13:12] != 2'b00) ? psd_pkg::E_SCRAMBLED
								: psd_pkg::E_LENGTH;
							phase_d = cfg.strict_mode ? psd_pkg::PH_STOPPED : psd_pkg::PH_SCAN;
							if (!cfg.strict_mode) shift_d = '1;
						end else begin
							rem_d = 16'(({1'b0, rem_q} - need_len));
							hlen_d = b - need;
							if (pts_flag) phase_d = psd_pkg::PH_PES_PTS;
							else if (b != 8'd0) phase_d = psd_pkg::PH_PES_SKIP;
							else phase_d = (16'(({1'b0, rem_q} - need_len)) != 16'd0)
								? psd_pkg::PH_PAYLOAD : psd_pkg::PH_CODE;
						end
					end
				end
				psd_pkg::PH_PES_PTS: begin
					if (count_q < 16'd4) shift_d = sh_in;
					else begin
						count_d = '0;
						res_valid = 1'b1;
						// prefix nibble must read 0010 or 0011 under mask 0x31
						if (!(c == 5'b10100 || c == 5'b11100)
							|| !shift_q[8] || !b[0]) begin
							res.kind = psd_pkg::K_ERROR;
							res.error_code = psd_pkg::E_MARKER;
							phase_d = cfg.strict_mode ? psd_pkg::PH_STOPPED : psd_pkg::PH_SCAN;
							if (!cfg.strict_mode) shift_d = '1;
						end else begin
							res.kind = psd_pkg::K_PTS;
							res.stream_id = cur_id_q;
							res.ts_base = pts_val;
							if (hlen_q != 8'd0) phase_d = psd_pkg::PH_PES_SKIP;
							else phase_d = (rem_q != 16'd0) ? psd_pkg::PH_PAYLOAD
								: psd_pkg::PH_CODE;
						end
					end
				end
				psd_pkg::PH_PES_SKIP: begin
					count_d = count_q;
					hlen_d = hlen_dec;
					if (hlen_dec == 8'd0) begin
						count_d = '0;
						phase_d = (rem_q != 16'd0) ? psd_pkg::PH_PAYLOAD : psd_pkg::PH_CODE;
					end
				end
				psd_pkg::PH_PAYLOAD: begin
					count_d = count_q;
					rem_d = rem_dec;
					res_valid = 1'b1;
					res.kind = psd_pkg::K_PAYLOAD;
					res.stream_id = cur_id_q;
					res.data_byte = b;
					res.last_of_packet = (rem_dec == 16'd0);
					if (rem_dec == 16'd0) begin
						count_d = '0;
						phase_d = psd_pkg::PH_CODE;
					end
				end
				default: count_d = count_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= psd_pkg::PH_BEGIN;
			shift_q <= '1;
			count_q <= '0;
			rem_q <= '0;
			hlen_q <= '0;
			flags_q <= '0;
			cur_id_q <= '0;
			stamp_q <= '0;
		end else begin
			phase_q <= phase_d;
			shift_q <= shift_d;
			count_q <= count_d;
			rem_q <= rem_d;
			hlen_q <= hlen_d;
			flags_q <= flags_d;
			cur_id_q <= cur_id_d;
			stamp_q <= stamp_d;
		end
	end

	`PSD_ASSERT_NEXT(a_stop_holds, clk, arst_n, phase_q == psd_pkg::PH_STOPPED,
		phase_q == psd_pkg::PH_STOPPED, "stopped state left before reset")
	`PSD_ASSERT_IMP(a_no_res_stopped, clk, arst_n, phase_q == psd_pkg::PH_STOPPED,
		!res_valid, "result produced while stopped")
	`PSD_ASSERT_IMP(a_no_push_full, clk, arst_n, q_full, !res_valid,
		"result produced while queue full")
endmodule

/* rtl/psd_queue.sv */
// Result queue between the parser and the output port.
`include "mpeg2_program_stream_demux_macros.svh"
module psd_queue #(
	parameter int Depth = psd_pkg::QueueDepth
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  psd_pkg::result_t push_data,
	output logic             full,
	output logic             out_valid,
	input  logic             out_ready,
	output psd_pkg::result_t out_data
);
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	psd_pkg::result_t mem_q [Depth];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic pop;

	assign full = (cnt_q == (AW+1)'(Depth));
	assign out_valid = (cnt_q != '0);
	assign pop = out_valid && out_ready;
	assign out_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + AW'(1);
			if (pop) rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	`PSD_ASSERT_IMP(a_no_overflow, clk, arst_n, full, !push, "push into full queue")
	`PSD_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= (AW+1)'(Depth),
		"queue count out of range")
endmodule

/* rtl/mpeg2_program_stream_demux.sv */
// Top level of the MPEG-2 program stream demux.
//
// Channels: "bytes" carries the program stream one byte per item; "results"
// carries payload bytes, SCR and PTS stamps, errors and end of stream.
// A plain write port (cfg_we, cfg_idx, cfg_data) sets strict mode and the
// stream filter; write it only while the block is idle.
// Throughput: one byte per cycle while the queue has space. The parser classifies a
// byte in the cycle it is accepted and pushes at most one result into a small queue.
// A result passes through the queue registers before it reaches the output.
// When the receiver stalls the queue absorbs up to QueueDepth results; once
// full, the byte channel drops ready and holds until space frees up.
// Reset: asynchronous, active low; the parser expects the stream to open with a pack code,
// the queue empties and the registers take their default values.
// Strict mode stops the block on an error or end code until the next reset.
module mpeg2_program_stream_demux #(
	parameter int QueueDepth = psd_pkg::QueueDepth
) (
	input  logic clk,
	input  logic arst_n,
	psd_byte_if.sink     bytes,
	psd_result_if.source results,
	input  logic                          cfg_we,
	input  logic [psd_pkg::CfgIdxW-1:0]   cfg_idx,
	input  logic [psd_pkg::CfgDataW-1:0]  cfg_data
);
	psd_pkg::cfg_t cfg_q;
	psd_pkg::result_t res, qout;
	logic res_valid, q_full;

	// hold the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.strict_mode <= 1'b0;
			cfg_q.filter_enable <= 1'b1;
			cfg_q.filter_id <= 8'hE0;
			cfg_q.filter_mask <= 8'hFF;
		end else if (cfg_we) begin
			case (cfg_idx)
				psd_pkg::REG_STRICT: cfg_q.strict_mode <= cfg_data[0];
				psd_pkg::REG_FEN:    cfg_q.filter_enable <= cfg_data[0];
				psd_pkg::REG_FID:    cfg_q.filter_id <= cfg_data;
				psd_pkg::REG_FMASK:  cfg_q.filter_mask <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: parse and classify
	psd_parser u_parser (
		.clk, .arst_n, .cfg(cfg_q),
		.in_valid(bytes.valid), .in_ready(bytes.ready), .in_byte(bytes.in_byte),
		.q_full, .res_valid, .res
	);

	// back: queue results toward the receiver
	psd_queue #(.Depth(QueueDepth)) u_queue (
		.clk, .arst_n, .push(res_valid), .push_data(res), .full(q_full),
		.out_valid(results.valid), .out_ready(results.ready), .out_data(qout)
	);

	assign results.kind = qout.kind;
	assign results.stream_id = qout.stream_id;
	assign results.data_byte = qout.data_byte;
	assign results.ts_base = qout.ts_base;
	assign results.ts_ext = qout.ts_ext;
	assign results.error_code = qout.error_code;
	assign results.last_of_packet = qout.last_of_packet;
endmodule

/* test/tb_mpeg2_program_stream_demux.sv */
// Testbench of the MPEG-2 program stream demux: a byte driver, a result checker and a predictor.
module tb_mpeg2_program_stream_demux;
	import psd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_idx = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	psd_byte_if byte_ch();
	psd_result_if res_ch();

	mpeg2_program_stream_demux i_dut (
		.clk(clk), .arst_n(arst_n), .bytes(byte_ch), .results(res_ch),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Stream bytes still to be offered, and the results the parser copy expects.
	logic [7:0] stream_q[$];
	result_t expected_q[$];
	int unsigned n_errors = 0;
	int unsigned snd_idle_pct = 0;
	int unsigned rcv_idle_pct = 0;
	int unsigned cycle_cnt = 0;

	// Predictor copy of the configuration registers.
	logic m_strict, m_fen;
	logic [7:0] m_fid, m_fmask;

	// Predictor copy of the parser state.
	phase_t ps_phase;
	logic [31:0] ps_shift;
	logic [15:0] ps_cnt, ps_rem, ps_flags;
	logic [7:0] ps_hlen, ps_id;
	logic [41:0] ps_stamp;
	logic ps_sel;

	task automatic enter(input phase_t p);
		ps_phase = p;
		ps_cnt = '0;
		if (p == PH_SCAN)
			ps_shift = '1;
	endtask

	task automatic push_result(input kind_t k, input logic [7:0] sid, input logic [7:0] d,
			input logic [32:0] base, input logic [8:0] ext, input err_t e, input logic last);
		result_t r;
		r.kind = k;
		r.stream_id = sid;
		r.data_byte = d;
		r.ts_base = base;
		r.ts_ext = ext;
		r.error_code = e;
		r.last_of_packet = last;
		expected_q.push_back(r);
	endtask

	// Report an error and either stop or go hunting for the next pack.
	task automatic parse_error(input err_t e);
		enter(m_strict ? PH_STOPPED : PH_SCAN);
		push_result(K_ERROR, 8'h00, 8'h00, '0, '0, e, 1'b0);
	endtask

	task automatic route_code(input logic [31:0] code);
		logic [7:0] id;
		logic match;
		id = code[7:0];
		if (code[31:8] != 24'h000001) begin
			parse_error(E_START);
			return;
		end
		match = m_fen && (((id ^ m_fid) & m_fmask) == 8'h00);
		if ((id >= 8'hC0 && id <= 8'hEF) || id == 8'hBD) begin
			ps_id = id;
			ps_sel = match;
			enter(match ? PH_PES_HDR : PH_PAD_LEN);
			return;
		end
		case (id)
			8'hB9: begin
				if (m_strict) begin
					enter(PH_STOPPED);
					push_result(K_END, 8'h00, 8'h00, '0, '0, E_START, 1'b0);
				end else begin
					enter(PH_SCAN);
				end
			end
			8'hBA: enter(PH_PACK);
			8'hBC, 8'hBE, 8'hBF, 8'hF0, 8'hF1, 8'hF2, 8'hF8, 8'hFF: enter(PH_PAD_LEN);
			default: parse_error(E_START);
		endcase
	endtask

	task automatic end_pes_header();
		if (ps_hlen != 8'h00)
			enter(PH_PES_SKIP);
		else
			enter(ps_rem != 16'h0000 ? PH_PAYLOAD : PH_CODE);
	endtask

	// Advance the parser copy by one accepted byte.
	task automatic predict_byte(input logic [7:0] b);
		logic [15:0] idx;
		logic [7:0] p0, p1, p2, p3, p4, f1;
		logic [32:0] base;
		logic [8:0] ext;
		logic has_pts;
		logic [7:0] need;
		idx = ps_cnt;
		case (ps_phase)
			PH_BEGIN: begin
				ps_shift = {ps_shift[23:0], b};
				ps_cnt++;
				if (ps_cnt == 16'd4) begin
					if (ps_shift == PackCode) enter(PH_PACK);
					else parse_error(E_START);
				end
			end
			PH_SCAN: begin
				ps_shift = {ps_shift[23:0], b};
				if (ps_shift == PackCode) enter(PH_PACK);
			end
			PH_PACK: begin
				ps_cnt++;
				if (idx < 16'd4) begin
					ps_shift = {ps_shift[23:0], b};
				end else if (idx == 16'd4) begin
					ps_flags = {8'h00, b};
				end else if (idx == 16'd5) begin
					{p0, p1, p2, p3} = ps_shift;
					p4 = ps_flags[7:0];
					base = {p0[5:3], p0[1:0], p1, p2[7:3], p2[1:0], p3, p4[7:3]};
					ext = {p4[1:0], b[7:1]};
					ps_stamp = {base, ext};
					if (!ps_shift[26]) ps_flags = 16'd2;
					else if (p0[7:6] != 2'b01 || !p2[2] || !p4[2] || !b[0]) ps_flags = 16'd3;
					else ps_flags = 16'd0;
				end else if (idx >= 16'd9) begin
					// Hold the pending marker verdict until the stuffing byte.
					if (ps_flags != 16'd0) begin
						parse_error(err_t'(ps_flags[2:0] - 3'd1));
					end else begin
						ps_rem = {13'd0, b[2:0]};
						enter(ps_rem != 16'h0000 ? PH_STUFF : PH_PACK_CODE);
						push_result(K_SCR, 8'h00, 8'h00, ps_stamp[41:9], ps_stamp[8:0],
							E_START, 1'b0);
					end
				end
			end
			PH_STUFF, PH_SKIP: begin
				if (ps_rem != 16'h0000) ps_rem--;
				if (ps_rem == 16'h0000) enter(ps_phase == PH_STUFF ? PH_PACK_CODE : PH_CODE);
			end
			PH_PACK_CODE, PH_CODE: begin
				ps_shift = {ps_shift[23:0], b};
				ps_cnt++;
				if (ps_cnt == 16'd4) begin
					if (ps_phase == PH_PACK_CODE && ps_shift == SystemCode) enter(PH_SYS);
					else route_code(ps_shift);
				end
			end
			PH_SYS: begin
				ps_cnt++;
				if (idx == 16'd0) ps_rem = {8'h00, b};
				else if (idx == 16'd1) ps_rem = {ps_rem[7:0], b};
				else if (idx == 16'd2) ps_flags = {b, 8'h00};
				else if (idx == 16'd4) ps_flags = {ps_flags[15:8], b};
				else if (idx >= 16'd7) begin
					if (!ps_flags[15] || !ps_flags[0]) parse_error(E_MARKER);
					else if (ps_rem < 16'd6) parse_error(E_LENGTH);
					else begin
						ps_rem = ps_rem - 16'd6;
						enter(ps_rem != 16'h0000 ? PH_SKIP : PH_CODE);
					end
				end
			end
			PH_PAD_LEN: begin
				ps_cnt++;
				if (idx == 16'd0) begin
					ps_rem = {8'h00, b};
				end else begin
					ps_rem = {ps_rem[7:0], b};
					enter(ps_rem != 16'h0000 ? PH_SKIP : PH_CODE);
				end
			end
			PH_PES_HDR: begin
				ps_cnt++;
				if (idx == 16'd0) ps_rem = {8'h00, b};
				else if (idx == 16'd1) ps_rem = {ps_rem[7:0], b};
				else if (idx == 16'd2) ps_flags = {b, 8'h00};
				else if (idx == 16'd3) ps_flags = {ps_flags[15:8], b};
				else begin
					f1 = ps_flags[15:8];
					has_pts = ps_flags[7];
					need = has_pts ? 8'd5 : 8'd0;
					ps_hlen = b;
					if (f1[7:6] != 2'b10) parse_error(E_MARKER);
					else if (f1[5:4] != 2'b00) parse_error(E_SCRAMBLED);
					else if (ps_hlen < need) parse_error(E_LENGTH);
					else if ({1'b0, ps_rem} < 17'd3 + {9'd0, ps_hlen}) parse_error(E_LENGTH);
					else begin
						ps_rem = ps_rem - 16'd3 - {8'd0, ps_hlen};
						ps_hlen = ps_hlen - need;
						if (has_pts) enter(PH_PES_PTS);
						else end_pes_header();
					end
				end
			end
			PH_PES_PTS: begin
				ps_cnt++;
				if (idx < 16'd4) begin
					ps_shift = {ps_shift[23:0], b};
				end else begin
					{p0, p1, p2, p3} = ps_shift;
					base = {p0[3:1], p1, p2[7:1], p3, b[7:1]};
					if (!((p0 & 8'h31) == 8'h21 || (p0 & 8'h31) == 8'h31) || !p2[0] || !b[0]) begin
						parse_error(E_MARKER);
					end else begin
						ps_stamp = {base, 9'd0};
						end_pes_header();
						push_result(K_PTS, ps_id, 8'h00, base, 9'd0, E_START, 1'b0);
					end
				end
			end
			PH_PES_SKIP: begin
				if (ps_hlen != 8'h00) ps_hlen--;
				if (ps_hlen == 8'h00) enter(ps_rem != 16'h0000 ? PH_PAYLOAD : PH_CODE);
			end
			PH_PAYLOAD: begin
				if (ps_rem != 16'h0000) ps_rem--;
				if (ps_rem == 16'h0000) enter(PH_CODE);
				push_result(K_PAYLOAD, ps_id, b, '0, '0, E_START, ps_rem == 16'h0000);
			end
			default: ;
		endcase
	endtask

	// Driver: offer the head of the stream queue, idling at random.
	always @(posedge clk or negedge arst_n) begin
		logic nv;
		if (!arst_n) begin
			byte_ch.valid <= 1'b0;
			byte_ch.in_byte <= 8'h00;
		end else begin
			nv = byte_ch.valid;
			if (byte_ch.valid && byte_ch.ready) begin
				predict_byte(stream_q.pop_front());
				nv = 1'b0;
			end
			// Keep an offered byte up until it is taken.
			if (!nv && stream_q.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
				nv = 1'b1;
				byte_ch.in_byte <= stream_q[0];
			end
			byte_ch.valid <= nv;
		end
	end

	// Hold off once for a long stretch so the result queue fills and stalls bytes.
	int unsigned hold_left = 0;
	bit hold_done = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && stream_q.size() > 60 && expected_q.size() > 0) begin
			hold_done <= 1'b1;
			hold_left <= 400;
		end
	end

	// Checker: compare each result with the oldest expectation, stall at random.
	always @(posedge clk or negedge arst_n) begin
		result_t e;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result kind %0d", res_ch.kind);
					n_errors++;
				end else begin
					e = expected_q.pop_front();
					if (res_ch.kind !== e.kind) begin
						$error("kind: expected %0d, got %0d", e.kind, res_ch.kind);
						n_errors++;
					end
					if (res_ch.stream_id !== e.stream_id) begin
						$error("stream_id: expected %0h, got %0h", e.stream_id, res_ch.stream_id);
						n_errors++;
					end
					if (res_ch.data_byte !== e.data_byte) begin
						$error("data_byte: expected %0h, got %0h", e.data_byte, res_ch.data_byte);
						n_errors++;
					end
					if (res_ch.ts_base !== e.ts_base) begin
						$error("ts_base: expected %0h, got %0h", e.ts_base, res_ch.ts_base);
						n_errors++;
					end
					if (res_ch.ts_ext !== e.ts_ext) begin
						$error("ts_ext: expected %0h, got %0h", e.ts_ext, res_ch.ts_ext);
						n_errors++;
					end
					if (res_ch.error_code !== e.error_code) begin
						$error("error_code: expected %0d, got %0d", e.error_code,
							res_ch.error_code);
						n_errors++;
					end
					if (res_ch.last_of_packet !== e.last_of_packet) begin
						$error("last_of_packet: expected %0b, got %0b", e.last_of_packet,
							res_ch.last_of_packet);
						n_errors++;
					end
				end
			end
			if (hold_left > 0) begin
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > 400000) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic put_byte(input logic [7:0] b);
		stream_q.push_back(b);
	endtask

	task automatic put_code(input logic [7:0] id);
		put_byte(8'h00); put_byte(8'h00); put_byte(8'h01); put_byte(id);
	endtask

	function automatic logic [7:0] rnd8();
		return 8'($urandom);
	endfunction

	// Build one pack with its packets. flaw picks one defect (0 means none);
	// scr_pat forces an all-ones (1) or all-zeros (2) clock reference.
	task automatic build_pack(input int flaw, input int scr_pat);
		logic [7:0] p[6];
		logic [7:0] id, f1;
		int n_pk, hdr, plen, len, n;
		bit pts, pes;
		if (flaw == 12)
			repeat ($urandom_range(1, 8)) put_byte(rnd8());
		put_code(8'hBA);
		p[0] = 8'h44 | (rnd8() & 8'h3B);
		p[1] = rnd8(); p[2] = rnd8() | 8'h04; p[3] = rnd8();
		p[4] = rnd8() | 8'h04; p[5] = rnd8() | 8'h01;
		if (scr_pat == 1) begin
			p[0] = 8'h7F; p[1] = 8'hFF; p[2] = 8'hFF; p[3] = 8'hFF; p[4] = 8'hFF; p[5] = 8'hFF;
		end else if (scr_pat == 2) begin
			p[0] = 8'h44; p[1] = 8'h00; p[2] = 8'h04; p[3] = 8'h00; p[4] = 8'h04; p[5] = 8'h01;
		end
		if (flaw == 1) p[0] = p[0] & 8'hFB;
		if (flaw == 2) begin
			case ($urandom_range(0, 4))
				0: p[0] = p[0] ^ 8'h80;
				1: p[0] = p[0] ^ 8'h40;
				2: p[2] = p[2] & 8'hFB;
				3: p[4] = p[4] & 8'hFB;
				default: p[5] = p[5] & 8'hFE;
			endcase
		end
		foreach (p[i]) put_byte(p[i]);
		repeat (3) put_byte(rnd8());
		n = (scr_pat != 0) ? 0 : $urandom_range(0, 7);
		put_byte((rnd8() & 8'hF8) | 8'(n));
		repeat (n) put_byte(rnd8());
		if (flaw == 3 || flaw == 4 || $urandom_range(0, 2) == 0) begin
			put_code(8'hBB);
			len = (flaw == 4) ? $urandom_range(0, 5) : 6 + $urandom_range(0, 3);
			put_byte(8'(len >> 8)); put_byte(8'(len));
			put_byte(flaw == 3 ? rnd8() & 8'h7F : rnd8() | 8'h80);
			put_byte(rnd8());
			put_byte(flaw == 3 ? rnd8() | 8'h01 : rnd8() | 8'h01);
			repeat (3) put_byte(rnd8());
			if (flaw != 4) repeat (len - 6) put_byte(rnd8());
		end
		n_pk = $urandom_range(1, 3);
		for (int k = 0; k < n_pk; k++) begin
			pes = 1'b1;
			case ($urandom_range(0, 9))
				0, 1, 2: id = 8'hE0;
				3: id = 8'hE1;
				4: id = 8'hC0;
				5: id = 8'hC5;
				6: id = 8'hBD;
				7: begin id = 8'hBE; pes = 1'b0; end
				8: begin id = 8'hBC; pes = 1'b0; end
				default: begin id = ($urandom_range(0, 1) != 0) ? 8'hF8 : 8'hFF; pes = 1'b0; end
			endcase
			if (flaw == 10 && k == 0) begin
				id = 8'($urandom_range(8'hB0, 8'hB8));
				pes = 1'b0;
			end
			if (flaw >= 5 && flaw <= 9 && k == 0) pes = 1'b1;
			if (flaw >= 5 && flaw <= 9 && k == 0 && !((id >= 8'hC0 && id <= 8'hEF) || id == 8'hBD))
				id = 8'hE0;
			put_code(id);
			if (!pes) begin
				len = $urandom_range(0, 8);
				put_byte(8'(len >> 8)); put_byte(8'(len));
				repeat (len) put_byte(rnd8());
				continue;
			end
			pts = ($urandom_range(0, 1) != 0) || (k == 0 && (flaw == 7 || flaw == 9));
			hdr = pts ? 5 + $urandom_range(0, 2) : $urandom_range(0, 2);
			if (flaw == 7 && k == 0) hdr = $urandom_range(0, 4);
			plen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
			len = 3 + hdr + plen;
			if (flaw == 8 && k == 0) len = $urandom_range(0, 2 + hdr);
			f1 = 8'h80 | (rnd8() & 8'h0F);
			if (flaw == 5 && k == 0) f1 = f1 ^ (($urandom_range(0, 1) != 0) ? 8'h40 : 8'hC0);
			if (flaw == 6 && k == 0) f1 = f1 | 8'($urandom_range(1, 3) << 4);
			put_byte(8'(len >> 8)); put_byte(8'(len));
			put_byte(f1);
			put_byte({pts, rnd8() & 7'h7F});
			put_byte(8'(hdr));
			if (pts) begin
				put_byte((($urandom_range(0, 1) != 0) ? 8'h21 : 8'h31) | (rnd8() & 8'h0E));
				put_byte(rnd8());
				put_byte(rnd8() | 8'h01);
				put_byte(rnd8());
				put_byte((flaw == 9 && k == 0) ? rnd8() & 8'hFE : rnd8() | 8'h01);
				hdr = (hdr > 5) ? hdr - 5 : 0;
			end
			repeat (hdr) put_byte(rnd8());
			repeat (plen) put_byte(rnd8());
		end
		if (flaw == 11) put_code(8'hB9);
	endtask

	task automatic write_reg(input reg_idx_t r, input logic [7:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= r;
		cfg_data <= v;
		case (r)
			REG_STRICT: m_strict = v[0];
			REG_FEN: m_fen = v[0];
			REG_FID: m_fid = v;
			REG_FMASK: m_fmask = v;
			default: ;
		endcase
	endtask

	task automatic settle();
		wait (stream_q.size() == 0 && !byte_ch.valid && expected_q.size() == 0);
		repeat (8) @(posedge clk);
	endtask

	// Settings per phase: strict, filter enable, filter id, filter mask.
	logic [17:0] phase_cfg[7] = '{
		{1'b0, 1'b1, 8'hE0, 8'hFF}, {1'b0, 1'b1, 8'hC0, 8'hE0}, {1'b0, 1'b0, 8'h00, 8'h00},
		{1'b0, 1'b1, 8'h00, 8'h00}, {1'b0, 1'b1, 8'hFF, 8'hFF}, {1'b0, 1'b1, 8'hBD, 8'hFF},
		{1'b1, 1'b1, 8'hE0, 8'hFF}
	};

	initial begin
		int unsigned start_len;
		m_strict = 1'b0; m_fen = 1'b1; m_fid = 8'hE0; m_fmask = 8'hFF;
		ps_phase = PH_BEGIN; ps_shift = '1; ps_cnt = '0; ps_rem = '0; ps_flags = '0;
		ps_hlen = '0; ps_stamp = '0; ps_id = '0; ps_sel = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < 7; ph++) begin
			// Rotate the idling regimes over the phases.
			case (ph % 3)
				0: begin snd_idle_pct = 35; rcv_idle_pct = 71; end
				1: begin snd_idle_pct = 71; rcv_idle_pct = 35; end
				default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
			endcase
			write_reg(REG_STRICT, {7'd0, phase_cfg[ph][17]});
			write_reg(REG_FEN, {7'd0, phase_cfg[ph][16]});
			write_reg(REG_FID, phase_cfg[ph][15:8]);
			write_reg(REG_FMASK, phase_cfg[ph][7:0]);
			@(posedge clk);
			cfg_we <= 1'b0;
			if (ph == 0) begin
				// Directed: extreme clock references, then each defect once.
				build_pack(0, 1);
				build_pack(0, 2);
				for (int f = 1; f <= 12; f++) build_pack(f, 0);
			end
			start_len = stream_q.size();
			while (stream_q.size() < start_len + 100)
				build_pack(($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 12), 0);
			settle();
		end
		if (expected_q.size() != 0) begin
			$error("%0d expected results never arrived", expected_q.size());
			n_errors++;
		end
		if (n_errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
